// ===== rtl/core/rcs_pkg.sv =====
// Package for the reliable channel sequencer.
// Holds payload and command types, widths and reset constants; no dependencies.
package rcs_pkg;

    localparam int SEQ_W  = 31;
    localparam int WORD_W = 32;
    localparam int PING_W = 16;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [PING_W-1:0] PING_INTERVAL_RST = 16'd1000;
    localparam logic [PING_W-1:0] PING_SAT          = 16'hFFFF;

    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_RX = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] now_ms;
        logic              message_pending;
        logic [WORD_W-1:0] rx_seq_word;
        logic [WORD_W-1:0] rx_ack_word;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] tx_seq_word;
        logic [WORD_W-1:0] tx_ack_word;
        logic              send_reliable;
        logic              take_message;
        logic              accepted;
        logic              new_reliable;
        logic [PING_W-1:0] ping_ms;
        logic [WORD_W-1:0] dropped_count;
        logic [WORD_W-1:0] good_count;
    } out_item_t;

    // Classified transaction as held in the command queue
    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] now_ms;
        logic              pending;
        logic [SEQ_W-1:0]  seq;
        logic              rel_msg;
        logic [SEQ_W-1:0]  ack;
        logic              rel_ack;
    } cmd_t;

endpackage

// ===== rtl/core/rcs_front.sv =====
// Front end of the reliable channel sequencer: classifies an input transaction.
// Splits the received header words into sequence and flag fields. Uses rcs_pkg.
module rcs_front (
    input  rcs_pkg::in_item_t item,
    output rcs_pkg::cmd_t     cmd
);
    import rcs_pkg::*;

    always_comb
    begin
        cmd.kind    = item.kind;
        cmd.now_ms  = item.now_ms;
        cmd.pending = (item.kind == KIND_TX) ? item.message_pending : 1'b0;
        cmd.seq     = item.rx_seq_word[SEQ_W-1:0];
        cmd.rel_msg = item.rx_seq_word[WORD_W-1];
        cmd.ack     = item.rx_ack_word[SEQ_W-1:0];
        cmd.rel_ack = item.rx_ack_word[WORD_W-1];
    end

endmodule

// ===== rtl/core/rcs_queue.sv =====
// Command queue between front and back ends of the reliable channel sequencer.
// Register-array FIFO of rcs_pkg::cmd_t entries. Uses rcs_pkg.
module rcs_queue #(
    parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcs_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output rcs_pkg::cmd_t head_data
);
    import rcs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/rcs_back.sv =====
// Back end of the reliable channel sequencer: channel state, header build and
// output register. One queued command per cycle unless stalled. Uses rcs_pkg.
module rcs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               cmd_valid,
    input  rcs_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output rcs_pkg::out_item_t out_data
);
    import rcs_pkg::*;

    logic [PING_W-1:0] ping_interval_reg;

    logic [SEQ_W-1:0]  out_seq_reg,      out_seq_next;
    logic              rel_bit_reg,      rel_bit_next;
    logic [SEQ_W-1:0]  last_sent_reg,    last_sent_next;
    logic [SEQ_W-1:0]  in_seq_reg,       in_seq_next;
    logic [SEQ_W-1:0]  in_ack_reg,       in_ack_next;
    logic              in_rel_ack_reg,   in_rel_ack_next;
    logic              in_rel_bit_reg,   in_rel_bit_next;
    logic              busy_reg,         busy_next;
    logic              pong_wait_reg,    pong_wait_next;
    logic [SEQ_W-1:0]  pong_seq_reg,     pong_seq_next;
    logic [WORD_W-1:0] ping_sent_reg,    ping_sent_next;
    logic [PING_W-1:0] ping_val_reg,     ping_val_next;
    logic [WORD_W-1:0] drop_cnt_reg,     drop_cnt_next;
    logic [WORD_W-1:0] good_cnt_reg,     good_cnt_next;

    logic              out_valid_reg,    out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         result;

    logic [WORD_W-1:0] elapsed;
    logic              resend;
    logic              slot_send;
    logic              send;
    logic              take;
    logic              stale;

    assign cmd_pop   = cmd_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign elapsed   = cmd.now_ms - ping_sent_reg;
    assign resend    = (in_ack_reg > last_sent_reg) && (in_rel_ack_reg != rel_bit_reg);
    assign slot_send = !busy_reg && (cmd.pending ||
                       ((elapsed >= {16'b0, ping_interval_reg}) && !pong_wait_reg));
    assign send      = resend || slot_send;
    assign take      = slot_send && cmd.pending;
    assign stale     = (cmd.seq <= in_seq_reg) && (cmd.seq != '0) && (in_seq_reg != '0);

    always_comb
    begin
        out_seq_next    = out_seq_reg;
        rel_bit_next    = rel_bit_reg;
        last_sent_next  = last_sent_reg;
        in_seq_next     = in_seq_reg;
        in_ack_next     = in_ack_reg;
        in_rel_ack_next = in_rel_ack_reg;
        in_rel_bit_next = in_rel_bit_reg;
        busy_next       = busy_reg;
        pong_wait_next  = pong_wait_reg;
        pong_seq_next   = pong_seq_reg;
        ping_sent_next  = ping_sent_reg;
        ping_val_next   = ping_val_reg;
        drop_cnt_next   = drop_cnt_reg;
        good_cnt_next   = good_cnt_reg;
        result          = '0;

        if (cmd.kind == KIND_TX)
        begin
            result.tx_seq_word   = {send, out_seq_reg};
            result.tx_ack_word   = {in_rel_bit_reg, in_seq_reg};
            result.send_reliable = send;
            result.take_message  = take;
            out_seq_next         = out_seq_reg + 1'b1;
            if (take)
            begin
                busy_next    = 1'b1;
                rel_bit_next = ~rel_bit_reg;
            end
            if (send)
            begin
                last_sent_next = out_seq_reg + 1'b1;
                if (!pong_wait_reg)
                begin
                    pong_wait_next = 1'b1;
                    pong_seq_next  = out_seq_reg;
                    ping_sent_next = cmd.now_ms;
                end
            end
        end
        else if (!stale)
        begin
            result.accepted     = 1'b1;
            result.new_reliable = cmd.rel_msg;
            if ({1'b0, cmd.seq} > ({1'b0, in_seq_reg} + 32'd1))
            begin
                drop_cnt_next = drop_cnt_reg + 1'b1;
            end
            if (cmd.rel_ack == rel_bit_reg)
            begin
                busy_next = 1'b0;
            end
            if (pong_wait_reg && (cmd.ack >= pong_seq_reg))
            begin
                pong_wait_next = 1'b0;
                ping_val_next  = (|elapsed[WORD_W-1:PING_W]) ? PING_SAT
                                                             : elapsed[PING_W-1:0];
            end
            in_seq_next     = cmd.seq;
            in_ack_next     = cmd.ack;
            in_rel_ack_next = cmd.rel_ack;
            in_rel_bit_next = in_rel_bit_reg ^ cmd.rel_msg;
            good_cnt_next   = good_cnt_reg + 1'b1;
        end

        result.ping_ms       = ping_val_next;
        result.dropped_count = drop_cnt_next;
        result.good_count    = good_cnt_next;

        out_valid_next = out_valid_reg && out_stall;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_interval_reg <= PING_INTERVAL_RST;
            out_seq_reg       <= '0;
            rel_bit_reg       <= 1'b0;
            last_sent_reg     <= '0;
            in_seq_reg        <= '0;
            in_ack_reg        <= '0;
            in_rel_ack_reg    <= 1'b0;
            in_rel_bit_reg    <= 1'b0;
            busy_reg          <= 1'b0;
            pong_wait_reg     <= 1'b0;
            pong_seq_reg      <= '0;
            ping_sent_reg     <= '0;
            ping_val_reg      <= '0;
            drop_cnt_reg      <= '0;
            good_cnt_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ping_interval_reg <= cfg_wr_data;
            end
            if (cmd_pop)
            begin
                out_seq_reg    <= out_seq_next;
                rel_bit_reg    <= rel_bit_next;
                last_sent_reg  <= last_sent_next;
                in_seq_reg     <= in_seq_next;
                in_ack_reg     <= in_ack_next;
                in_rel_ack_reg <= in_rel_ack_next;
                in_rel_bit_reg <= in_rel_bit_next;
                busy_reg       <= busy_next;
                pong_wait_reg  <= pong_wait_next;
                pong_seq_reg   <= pong_seq_next;
                ping_sent_reg  <= ping_sent_next;
                ping_val_reg   <= ping_val_next;
                drop_cnt_reg   <= drop_cnt_next;
                good_cnt_reg   <= good_cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/reliable_channel_sequencer.sv =====
// Reliable channel sequencer top level: front end, command queue, back end.
// Accepted inputs enter the command queue, then the output register when popped.
// Throughput: one transaction per cycle while the output is not stalled; the back
// end updates channel state on each pop; the queue absorbs up to QUEUE_DEPTH transactions.
// Reset (rst_n, async): queue and output empty, all channel state zero,
// ping interval 1000 ms. Depends on rcs_pkg, rcs_front, rcs_queue, rcs_back.
module reliable_channel_sequencer #(
    parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  rcs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rcs_pkg::out_item_t out_data
);
    import rcs_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign in_stall = q_full;

    rcs_front u_front (
        .item (in_data),
        .cmd  (front_cmd)
    );

    rcs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !q_full),
        .push_data  (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_cmd)
    );

    rcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (q_valid),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== rtl/core/rcs_checker.sv =====
// Port-level checks for the reliable channel sequencer, bound to the top level.
// Uses rcs_pkg.
module rcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input rcs_pkg::out_item_t out_data
);
    import rcs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    a_flag_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.tx_seq_word[WORD_W-1] == out_data.send_reliable)
        else $error("sequence word flag disagrees with send_reliable");

    a_take_sends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.take_message |-> out_data.send_reliable)
        else $error("message taken without reliable send");

    a_rx_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.accepted |->
            out_data.tx_seq_word == '0 && out_data.tx_ack_word == '0 &&
            !out_data.take_message)
        else $error("accepted receive carries transmit header");

    a_newrel_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_reliable |-> out_data.accepted)
        else $error("new_reliable on a rejected or transmit transaction");

endmodule

bind reliable_channel_sequencer rcs_checker u_rcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
